>>> hw/rtl/tsprcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsprcb_pkg - shared types and constants of the reduced-cost bound engine
// Command codes, sequencer states and the fixed widths of the port words.
// ----------------------------------------------------------------------------
package tsprcb_pkg;

	// Defaults for the top level parameters
	localparam int DEF_MAX_VERTICES = 16;
	localparam int DEF_COST_BITS    = 16;

	// Fixed port widths
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 4;
	localparam int COST_W  = 17;
	localparam int VC_W    = 5;
	localparam int BOUND_W = 22;

	localparam logic [VC_W-1:0]    VC_RESET  = 5'd16;
	localparam logic [BOUND_W-1:0] BOUND_MAX = '1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REDUCE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

	// Sequencer states: idle, copy pass, row scan and subtract, column scan and subtract, finish
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_ROW_SCAN,
		ST_ROW_SUB,
		ST_COL_SCAN,
		ST_COL_SUB,
		ST_FINISH
	} state_t;

endpackage

>>> hw/rtl/tsprcb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsprcb_ram - simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tsprcb_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 17
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/tsp_reduced_cost_bound.sv
`timescale 1ns / 1ps
// Load: one word a cycle while idle, no result. Reduce / evaluate with side n:
// one copy pass and four row/column passes over the n x n corner, a line at a
// time; the next word is taken once the result reaches the output register.
// Out-of-range evaluate or side 0 reduce: no pass is run. A result waits in the
// output register, holding the engine only while an older one is still unread.
// Reset: side 16, no result pending, matrix contents undefined until loaded.
// ----------------------------------------------------------------------------
// tsp_reduced_cost_bound - branch-and-bound lower-bound engine
// Holds a cost matrix in RAM; reduces it in place or evaluates a trial edge
// on a scratch copy, returning the sum of row and column minima (plus the trial edge cost on evaluate).
// ----------------------------------------------------------------------------
module tsp_reduced_cost_bound #(
	parameter int MAX_VERTICES = tsprcb_pkg::DEF_MAX_VERTICES,
	parameter int COST_BITS    = tsprcb_pkg::DEF_COST_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsprcb_pkg::VC_W-1:0]       cfg_data,
	// command words
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tsprcb_pkg::CMD_W-1:0]      cmd,
	input  logic [tsprcb_pkg::IDX_W-1:0]      row_index,
	input  logic [tsprcb_pkg::IDX_W-1:0]      col_index,
	input  logic signed [tsprcb_pkg::COST_W-1:0] cost,
	// result words
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tsprcb_pkg::BOUND_W-1:0]    bound,
	output logic                              infeasible
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int AW = 2 * IW;
	localparam int EW = COST_BITS + 1;
	localparam logic [32:0] COST_MAX = (33'd1 << COST_BITS) - 33'd1;
	localparam logic [EW-1:0] NONE_ENTRY = {1'b1, {COST_BITS{1'b0}}};

	tsprcb_pkg::state_t state_q, state_d;

	logic [tsprcb_pkg::VC_W-1:0] vcount_q;
	logic [NW-1:0]     n_use, n_q;
	logic [IW-1:0]     line_q, line_d;
	logic [NW-1:0]     elem_q, elem_d;
	logic              is_eval_q;
	logic [IW-1:0]     r_q, c_q;
	logic [COST_BITS-1:0] min_q;
	logic              found_q;
	logic [tsprcb_pkg::BOUND_W-1:0] sum_q;
	logic              empty_q;
	logic              vld_s1;
	logic [AW-1:0]     addr_s1;
	logic              out_valid_q;
	logic [tsprcb_pkg::BOUND_W-1:0] bound_q;
	logic              infeas_q;

	logic in_fire, out_load;
	logic eval_ok, load_ok;
	logic in_pass, rowwise, elem_end, last_line, rd_en;
	logic [AW-1:0] pass_addr;

	logic          main_we, main_re, scr_we, scr_re;
	logic [AW-1:0] main_waddr, load_addr;
	logic [EW-1:0] main_wdata, scr_wdata, main_rdata, scr_rdata;
	logic [EW-1:0] rd_ent, sub_ent, load_ent;
	logic          ent_none;
	logic [COST_BITS-1:0] ent_val;
	logic [IW-1:0] row_s1, col_s1;
	logic          blocked, edge_hit, skip_line;
	logic [15:0]   raw_mag;
	logic          raw_over;

	logic [COST_BITS-1:0] addend;
	logic [32:0]   sum_wide;
	logic [tsprcb_pkg::BOUND_W-1:0] sum_sat;

	// side in use, clipped to the matrix size
	always_comb begin
		if (32'(vcount_q) > MAX_VERTICES) begin
			n_use = NW'(MAX_VERTICES);
		end else begin
			n_use = NW'(vcount_q);
		end
	end

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == tsprcb_pkg::ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_load   = (state_q == tsprcb_pkg::ST_FINISH) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign bound      = bound_q;
	assign infeasible = infeas_q;

	assign eval_ok = (32'(row_index) < 32'(n_use)) && (32'(col_index) < 32'(n_use));
	assign load_ok = (32'(row_index) < MAX_VERTICES) && (32'(col_index) < MAX_VERTICES);

	// pass addressing: one line of n reads, then a gap with no read
	assign in_pass = (state_q == tsprcb_pkg::ST_COPY) || (state_q == tsprcb_pkg::ST_ROW_SCAN) ||
			(state_q == tsprcb_pkg::ST_ROW_SUB) || (state_q == tsprcb_pkg::ST_COL_SCAN) ||
			(state_q == tsprcb_pkg::ST_COL_SUB);
	assign rowwise = (state_q == tsprcb_pkg::ST_COPY) || (state_q == tsprcb_pkg::ST_ROW_SCAN) ||
			(state_q == tsprcb_pkg::ST_ROW_SUB);
	assign elem_end  = (elem_q == n_q);
	assign last_line = ((NW'(line_q) + NW'(1)) == n_q);
	assign rd_en     = in_pass && !elem_end;
	assign pass_addr = rowwise ? {line_q, elem_q[IW-1:0]} : {elem_q[IW-1:0], line_q};
	assign main_re   = rd_en && (state_q == tsprcb_pkg::ST_COPY);
	assign scr_re    = rd_en && (state_q != tsprcb_pkg::ST_COPY);

	// next state and pass counters
	always_comb begin
		state_d = state_q;
		line_d  = line_q;
		elem_d  = elem_q;
		unique case (state_q)
			tsprcb_pkg::ST_IDLE: begin
				line_d = '0;
				elem_d = '0;
				if (in_fire) begin
					if (cmd == tsprcb_pkg::CMD_REDUCE) begin
						state_d = (n_use == '0) ? tsprcb_pkg::ST_FINISH : tsprcb_pkg::ST_COPY;
					end else if (cmd == tsprcb_pkg::CMD_EVAL) begin
						state_d = eval_ok ? tsprcb_pkg::ST_COPY : tsprcb_pkg::ST_FINISH;
					end
				end
			end
			tsprcb_pkg::ST_COPY, tsprcb_pkg::ST_ROW_SCAN, tsprcb_pkg::ST_ROW_SUB,
			tsprcb_pkg::ST_COL_SCAN, tsprcb_pkg::ST_COL_SUB: begin
				if (!elem_end) begin
					elem_d = elem_q + NW'(1);
				end else begin
					elem_d = '0;
					unique case (state_q)
						tsprcb_pkg::ST_COPY: begin
							state_d = last_line ? tsprcb_pkg::ST_ROW_SCAN : tsprcb_pkg::ST_COPY;
							line_d  = last_line ? '0 : line_q + IW'(1);
						end
						tsprcb_pkg::ST_ROW_SCAN: begin
							state_d = tsprcb_pkg::ST_ROW_SUB;
						end
						tsprcb_pkg::ST_ROW_SUB: begin
							state_d = last_line ? tsprcb_pkg::ST_COL_SCAN : tsprcb_pkg::ST_ROW_SCAN;
							line_d  = last_line ? '0 : line_q + IW'(1);
						end
						tsprcb_pkg::ST_COL_SCAN: begin
							state_d = tsprcb_pkg::ST_COL_SUB;
						end
						default: begin
							state_d = last_line ? tsprcb_pkg::ST_FINISH : tsprcb_pkg::ST_COL_SCAN;
							line_d  = last_line ? '0 : line_q + IW'(1);
						end
					endcase
				end
			end
			tsprcb_pkg::ST_FINISH: begin
				if (out_load) begin
					state_d = tsprcb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tsprcb_pkg::ST_IDLE;
			end
		endcase
	end

	// load word: negative is no edge, large costs saturate
	assign raw_mag  = cost[15:0];
	assign raw_over = ({17'd0, raw_mag} > COST_MAX);
	assign load_ent = cost[16] ? NONE_ENTRY :
			(raw_over ? {1'b0, {COST_BITS{1'b1}}} : {1'b0, COST_BITS'(raw_mag)});
	assign load_addr = {IW'(row_index), IW'(col_index)};

	// stage 1: RAM data for the read issued last cycle
	assign rd_ent   = (state_q == tsprcb_pkg::ST_COPY) ? main_rdata : scr_rdata;
	assign ent_none = rd_ent[COST_BITS];
	assign ent_val  = rd_ent[COST_BITS-1:0];
	assign row_s1   = addr_s1[AW-1:IW];
	assign col_s1   = addr_s1[IW-1:0];
	assign blocked  = is_eval_q && ((row_s1 == r_q) || (col_s1 == c_q) ||
			((row_s1 == c_q) && (col_s1 == r_q)));
	assign edge_hit = vld_s1 && (state_q == tsprcb_pkg::ST_COPY) && is_eval_q &&
			(row_s1 == r_q) && (col_s1 == c_q);
	assign sub_ent  = ent_none ? rd_ent : {1'b0, ent_val - min_q};
	assign skip_line = is_eval_q &&
			(((state_q == tsprcb_pkg::ST_ROW_SUB) && (line_q == r_q)) ||
			((state_q == tsprcb_pkg::ST_COL_SUB) && (line_q == c_q)));

	// scratch write: copy with blocking, or subtract write-back
	assign scr_we = vld_s1 && ((state_q == tsprcb_pkg::ST_COPY) ||
			(state_q == tsprcb_pkg::ST_ROW_SUB) || (state_q == tsprcb_pkg::ST_COL_SUB));
	assign scr_wdata = (state_q == tsprcb_pkg::ST_COPY) ? (blocked ? NONE_ENTRY : rd_ent) : sub_ent;

	// main write: loads when idle, final column results on reduce
	always_comb begin
		if (state_q == tsprcb_pkg::ST_IDLE) begin
			main_we    = in_fire && (cmd == tsprcb_pkg::CMD_LOAD) && load_ok;
			main_waddr = load_addr;
			main_wdata = load_ent;
		end else begin
			main_we    = vld_s1 && (state_q == tsprcb_pkg::ST_COL_SUB) && !is_eval_q;
			main_waddr = addr_s1;
			main_wdata = sub_ent;
		end
	end

	// saturating bound accumulator
	assign addend   = (state_q == tsprcb_pkg::ST_COPY) ? ent_val : min_q;
	assign sum_wide = 33'(sum_q) + 33'(addend);
	assign sum_sat  = (sum_wide > 33'(tsprcb_pkg::BOUND_MAX)) ? tsprcb_pkg::BOUND_MAX :
			sum_wide[tsprcb_pkg::BOUND_W-1:0];

	tsprcb_ram #(.ADDR_W(AW), .DATA_W(EW)) u_main_ram (
		.clk   (clk),
		.we    (main_we),
		.waddr (main_waddr),
		.wdata (main_wdata),
		.re    (main_re),
		.raddr (pass_addr),
		.rdata (main_rdata)
	);

	tsprcb_ram #(.ADDR_W(AW), .DATA_W(EW)) u_scr_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (addr_s1),
		.wdata (scr_wdata),
		.re    (scr_re),
		.raddr (pass_addr),
		.rdata (scr_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsprcb_pkg::ST_IDLE;
			line_q      <= '0;
			elem_q      <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			vcount_q    <= tsprcb_pkg::VC_RESET;
		end else begin
			state_q <= state_d;
			line_q  <= line_d;
			elem_q  <= elem_d;
			vld_s1  <= rd_en;
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= pass_addr;
		if (in_fire) begin
			n_q       <= n_use;
			is_eval_q <= (cmd == tsprcb_pkg::CMD_EVAL);
			r_q       <= IW'(row_index);
			c_q       <= IW'(col_index);
			sum_q     <= '0;
			empty_q   <= (cmd == tsprcb_pkg::CMD_EVAL) && !eval_ok;
			min_q     <= '0;
			found_q   <= 1'b0;
		end
		// trial edge cost picked up during the copy
		if (edge_hit) begin
			if (ent_none) begin
				empty_q <= 1'b1;
			end else begin
				sum_q <= sum_sat;
			end
		end
		// running minimum over the line
		if (vld_s1 && ((state_q == tsprcb_pkg::ST_ROW_SCAN) ||
				(state_q == tsprcb_pkg::ST_COL_SCAN))) begin
			if (!ent_none && (!found_q || (ent_val < min_q))) begin
				min_q   <= ent_val;
				found_q <= 1'b1;
			end
		end
		// end of a subtract line: add its minimum or flag it empty, except on the trial row or column
		if (elem_end && ((state_q == tsprcb_pkg::ST_ROW_SUB) ||
				(state_q == tsprcb_pkg::ST_COL_SUB))) begin
			if (!skip_line) begin
				if (found_q) begin
					sum_q <= sum_sat;
				end else begin
					empty_q <= 1'b1;
				end
			end
			min_q   <= '0;
			found_q <= 1'b0;
		end
		if (out_load) begin
			bound_q  <= sum_q;
			infeas_q <= empty_q;
		end
	end

	// a result appears only out of the finish state
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tsprcb_pkg::ST_FINISH))
		else $error("result raised outside finish");

	// scratch RAM is quiet between commands
	a_scr_quiet_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsprcb_pkg::ST_IDLE) |-> !scr_we)
		else $error("scratch write while idle");

	// stored matrix touched by a pass only in the column write-back of reduce
	a_main_wb_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		(main_we && (state_q != tsprcb_pkg::ST_IDLE)) |->
		((state_q == tsprcb_pkg::ST_COL_SUB) && !is_eval_q))
		else $error("stored matrix written outside reduce write-back");

	// element counter never runs past the side
	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tsprcb_pkg::ST_COPY) || (state_q == tsprcb_pkg::ST_ROW_SCAN) ||
		(state_q == tsprcb_pkg::ST_ROW_SUB) || (state_q == tsprcb_pkg::ST_COL_SCAN) ||
		(state_q == tsprcb_pkg::ST_COL_SUB)) |-> (elem_q <= n_q))
		else $error("element counter out of range");

	// a stalled result holds the finish state
	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == tsprcb_pkg::ST_FINISH) && out_valid_q && !out_ready) |=>
		(state_q == tsprcb_pkg::ST_FINISH))
		else $error("finish left while output stalled");

endmodule

>>> test/bound_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bound_check_pkg - result predictor for the reduced-cost bound engine
// Keeps a shadow cost matrix and the side in use. Works out the bound and
// infeasible flag of every reduce or evaluate word taken by the block.
// Checks each result word against the oldest expected one.
// ----------------------------------------------------------------------------
package bound_check_pkg;
	import tsprcb_pkg::*;

	localparam int MAX_V    = DEF_MAX_VERTICES;
	localparam int COST_MAX = (1 << DEF_COST_BITS) - 1;
	localparam int NO_LINK  = -1;

	typedef struct packed {
		logic [BOUND_W-1:0] bound;
		logic               infeasible;
	} bound_word_t;

	class bound_scoreboard;
		int          cost_mat [MAX_V][MAX_V];
		int          work [MAX_V][MAX_V];
		int          side;
		bit          any_empty;
		bound_word_t expected [$];
		int          errors;
		int          checked;
		int          n_reduce;
		int          n_eval;
		int          n_infeasible;

		function new();
			side         = int'(VC_RESET);
			errors       = 0;
			checked      = 0;
			n_reduce     = 0;
			n_eval       = 0;
			n_infeasible = 0;
		endfunction

		function void set_side(logic [VC_W-1:0] v);
			side = int'(v);
		endfunction

		// Side values above the array size act as the full array
		function int span();
			return (side > MAX_V) ? MAX_V : side;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Row pass then column pass over the n x n corner of work.
		// Row skip_r and column skip_c contribute nothing.
		function int reduce_work(int n, int skip_r, int skip_c);
			int total;
			int lo;
			int i;
			int j;
			total = 0;
			for (i = 0; i < n; i++) begin
				if (i == skip_r)
					continue;
				lo = -1;
				for (j = 0; j < n; j++)
					if (work[i][j] >= 0 && (lo < 0 || work[i][j] < lo))
						lo = work[i][j];
				if (lo < 0) begin
					any_empty = 1'b1;
				end else begin
					for (j = 0; j < n; j++)
						if (work[i][j] >= 0)
							work[i][j] -= lo;
					total += lo;
				end
			end
			for (j = 0; j < n; j++) begin
				if (j == skip_c)
					continue;
				lo = -1;
				for (i = 0; i < n; i++)
					if (work[i][j] >= 0 && (lo < 0 || work[i][j] < lo))
						lo = work[i][j];
				if (lo < 0) begin
					any_empty = 1'b1;
				end else begin
					for (i = 0; i < n; i++)
						if (work[i][j] >= 0)
							work[i][j] -= lo;
					total += lo;
				end
			end
			return total;
		endfunction

		function void queue_bound(int total, bit flag);
			bound_word_t w;
			w.bound      = (total > int'(BOUND_MAX)) ? BOUND_MAX : total[BOUND_W-1:0];
			w.infeasible = flag;
			if (flag)
				n_infeasible++;
			expected.insert(expected.size(), w);
		endfunction

		// Called for every command word the block accepts
		function void note_input(logic [CMD_W-1:0] op, logic [IDX_W-1:0] r,
				logic [IDX_W-1:0] c, logic signed [COST_W-1:0] val);
			int n;
			int total;
			int link;
			int i;
			int j;
			n = span();
			any_empty = 1'b0;
			case (op)
				CMD_LOAD: begin
					if (val < 0)
						cost_mat[r][c] = NO_LINK;
					else
						cost_mat[r][c] = (int'(val) > COST_MAX) ? COST_MAX : int'(val);
				end
				CMD_REDUCE: begin
					n_reduce++;
					for (i = 0; i < MAX_V; i++)
						for (j = 0; j < MAX_V; j++)
							work[i][j] = cost_mat[i][j];
					total = reduce_work(n, MAX_V, MAX_V);
					for (i = 0; i < MAX_V; i++)
						for (j = 0; j < MAX_V; j++)
							cost_mat[i][j] = work[i][j];
					queue_bound(total, any_empty);
				end
				CMD_EVAL: begin
					n_eval++;
					if (int'(r) >= n || int'(c) >= n) begin
						queue_bound(0, 1'b1);
					end else begin
						for (i = 0; i < MAX_V; i++)
							for (j = 0; j < MAX_V; j++)
								work[i][j] = cost_mat[i][j];
						link = work[r][c];
						// block the trial row, column and the way back
						for (i = 0; i < n; i++) begin
							work[i][c] = NO_LINK;
							work[r][i] = NO_LINK;
						end
						work[c][r] = NO_LINK;
						total = reduce_work(n, int'(r), int'(c));
						if (link < 0)
							any_empty = 1'b1;
						else
							total += link;
						queue_bound(total, any_empty);
					end
				end
				default: ;
			endcase
		endfunction

		// Called for every result word the block hands over
		function void check_result(logic [BOUND_W-1:0] b, logic inf);
			bound_word_t w;
			if (expected.size() == 0) begin
				$error("result word with nothing expected: bound %0d infeasible %0b", b, inf);
				errors++;
				return;
			end
			w = expected.pop_front();
			checked++;
			if (b !== w.bound) begin
				$error("bound: expected %0d, got %0d", w.bound, b);
				errors++;
			end
			if (inf !== w.infeasible) begin
				$error("infeasible: expected %0b, got %0b", w.infeasible, inf);
				errors++;
			end
		endfunction
	endclass

endpackage

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - regression bench for the reduced-cost bound engine
// Drives load, reduce and evaluate words through the valid/ready channels
// with random gaps and stalls, changes the matrix side between phases, and
// checks every result word against a shadow model of the engine.
// ----------------------------------------------------------------------------
module tb;
	import tsprcb_pkg::*;
	import bound_check_pkg::*;

	localparam logic [CMD_W-1:0]          CMD_UNUSED = 2'd3;
	localparam logic signed [COST_W-1:0]  NO_EDGE    = 17'h1FFFF;
	localparam logic signed [COST_W-1:0]  COST_MIN   = 17'h10000;
	localparam logic signed [COST_W-1:0]  COST_TOP   = 17'h0FFFF;
	// slowest command at full side, plus margin
	localparam int SETTLE_CYCLES = 5 * 16 * 17 + 2 + 16;
	localparam int STALL_LIMIT   = 20000;
	localparam int PHASE_ITEMS   = 30;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [VC_W-1:0]             cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [CMD_W-1:0]            cmd;
	logic [IDX_W-1:0]            row_index;
	logic [IDX_W-1:0]            col_index;
	logic signed [COST_W-1:0]    cost;
	logic                        out_valid;
	logic                        out_ready;
	logic [BOUND_W-1:0]          bound;
	logic                        infeasible;

	bound_scoreboard sb;
	bit              loaded [MAX_V][MAX_V];
	int              in_idle_pct  = 24;
	int              out_idle_pct = 24;
	int              items_sent   = 0;
	int              sides_seen   = 0;
	int              quiet_cycles = 0;

	tsp_reduced_cost_bound i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.row_index  (row_index),
		.col_index  (col_index),
		.cost       (cost),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bound      (bound),
		.infeasible (infeasible)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, changed on the falling edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// Result words are checked as they are taken
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(bound, infeasible);
	end

	// Watchdog: too long without any word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tsp_reduced_cost_bound regression: fail");
			$finish;
		end
	end

	// Random cost; sparse matrices get many missing edges
	function automatic logic signed [COST_W-1:0] rand_cost(bit sparse);
		int          p;
		int          lim;
		logic [15:0] raw;
		p   = $urandom_range(99);
		lim = sparse ? 50 : 12;
		raw = 16'($urandom_range(65535));
		if (p < lim)
			return NO_EDGE;
		if (p < lim + 5)
			return {1'b1, raw};
		if (p < lim + 8)
			return COST_TOP;
		if (p < lim + 20)
			return {1'b0, raw};
		return COST_W'($urandom_range(30));
	endfunction

	// One command word; entered and left on a falling edge
	task automatic send_word(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [COST_W-1:0] val);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		row_index <= r;
		col_index <= c;
		cost      <= val;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, r, c, val);
		if (op == CMD_LOAD)
			loaded[r][c] = 1'b1;
		if (op != CMD_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	// Load every entry of the active corner not yet written since reset
	task automatic fill_corner();
		int n;
		n = sb.span();
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (!loaded[i][j])
					send_word(CMD_LOAD, IDX_W'(i), IDX_W'(j), rand_cost(1'b0));
	endtask

	// Side change: drain all results, let loads settle, then write
	task automatic write_side(input logic [VC_W-1:0] v);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_side(v);
		sides_seen++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random step; mostly loads and commands on the active corner
	task automatic random_step();
		int               n;
		int               pick;
		bit               sparse;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		n      = sb.span();
		pick   = $urandom_range(99);
		sparse = ($urandom_range(2) == 0);
		if (n > 0 && $urandom_range(9) < 8) begin
			r = IDX_W'($urandom_range(n - 1));
			c = IDX_W'($urandom_range(n - 1));
		end else begin
			r = IDX_W'($urandom_range(15));
			c = IDX_W'($urandom_range(15));
		end
		if (pick < 8 && n <= 8) begin
			// fresh matrix on the corner
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					send_word(CMD_LOAD, IDX_W'(i), IDX_W'(j), rand_cost(sparse));
		end else if (pick < 48) begin
			send_word(CMD_LOAD, r, c, rand_cost(1'b0));
		end else if (pick < 65) begin
			fill_corner();
			send_word(CMD_REDUCE, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
				rand_cost(1'b0));
		end else if (pick < 95) begin
			fill_corner();
			send_word(CMD_EVAL, r, c, rand_cost(1'b0));
		end else begin
			send_word(CMD_UNUSED, r, c, rand_cost(1'b0));
		end
	endtask

	// Main sequence
	initial begin
		int side_plan [11];
		int target;
		side_plan = '{4, 0, 5, 16, 2, 31, 1, 6, 3, 8, 4};
		sb        = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		cmd       = CMD_LOAD;
		row_index = '0;
		col_index = '0;
		cost      = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: 3 x 3 corner with missing edges and extreme costs
		write_side(5'd3);
		send_word(CMD_LOAD, 4'd0, 4'd0, NO_EDGE);
		send_word(CMD_LOAD, 4'd0, 4'd1, 17'sd10);
		send_word(CMD_LOAD, 4'd0, 4'd2, COST_TOP);
		send_word(CMD_LOAD, 4'd1, 4'd0, 17'sd7);
		send_word(CMD_LOAD, 4'd1, 4'd1, NO_EDGE);
		send_word(CMD_LOAD, 4'd1, 4'd2, 17'sd3);
		send_word(CMD_LOAD, 4'd2, 4'd0, 17'sd4);
		send_word(CMD_LOAD, 4'd2, 4'd1, 17'sd12);
		send_word(CMD_LOAD, 4'd2, 4'd2, COST_MIN);
		// stored though outside the side in use
		send_word(CMD_LOAD, 4'd15, 4'd15, COST_TOP);
		send_word(CMD_LOAD, 4'd15, 4'd0, 17'sd0);
		send_word(CMD_EVAL, 4'd0, 4'd1, 17'sd0);
		// trial edge that does not exist
		send_word(CMD_EVAL, 4'd0, 4'd0, 17'sd0);
		// trial vertex beyond the side
		send_word(CMD_EVAL, 4'd15, 4'd2, 17'sd0);
		send_word(CMD_EVAL, 4'd2, 4'd15, 17'sd0);
		send_word(CMD_REDUCE, 4'd15, 4'd15, COST_MIN);
		send_word(CMD_UNUSED, 4'd15, 4'd15, COST_TOP);
		// empty row
		send_word(CMD_LOAD, 4'd1, 4'd0, NO_EDGE);
		send_word(CMD_LOAD, 4'd1, 4'd2, COST_MIN);
		send_word(CMD_REDUCE, 4'd0, 4'd0, 17'sd0);
		send_word(CMD_EVAL, 4'd0, 4'd1, 17'sd0);
		send_word(CMD_EVAL, 4'd2, 4'd0, 17'sd0);

		// Random phases over a range of sides, two of them with no idling
		foreach (side_plan[k]) begin
			in_idle_pct  = (k == 2 || k == 7) ? 0 : 24;
			out_idle_pct = in_idle_pct;
			write_side(VC_W'(side_plan[k]));
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_step();
		end

		// Drain and look for stray results
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d command words over %0d side settings (0, 1, 2 and above 16 too)",
			items_sent, sides_seen);
		$display("%0d reduce, %0d evaluate, %0d result words checked, %0d flagged infeasible",
			sb.n_reduce, sb.n_eval, sb.checked, sb.n_infeasible);
		if (sb.errors == 0)
			$display("tsp_reduced_cost_bound regression: pass");
		else
			$display("tsp_reduced_cost_bound regression: fail");
		$finish;
	end

endmodule
